// ===== rtl/core/yfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_pkg: shared types and constants of the Yee field stencil update unit
// Q16.16 field words, Q1.30 coefficients and the job record that the front
// end hands to the arithmetic back end.
// ----------------------------------------------------------------------------
package yfs_pkg;

	localparam int MAX_ROW     = 1024;
	localparam int COL_W       = $clog2(MAX_ROW);
	localparam int ROW_W       = 16;
	localparam int WIDTH_W     = COL_W + 1;
	localparam int COEF_W      = 31;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 31;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_T = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;

	localparam logic MODE_B = 1'b0;
	localparam logic MODE_E = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(3);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_ROW);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_ROW);

	// coefficient selector of one product term
	localparam logic [1:0] COEF_NONE = 2'd0;
	localparam logic [1:0] COEF_X    = 2'd1;
	localparam logic [1:0] COEF_Y    = 2'd2;
	localparam logic [1:0] COEF_T    = 2'd3;

	typedef logic signed [31:0] word_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [63:0] prod_t;

	typedef struct packed {
		logic [COEF_W-1:0] cx;
		logic [COEF_W-1:0] cy;
		logic [COEF_W-1:0] ct;
	} coef_t;

	typedef struct packed {
		logic [1:0] sel;
		logic       neg;
		diff_t      diff;
	} term_t;

	typedef struct packed {
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		word_t [2:0]        old;
		term_t [2:0][2:0]   terms;
	} job_t;

	function automatic diff_t sub33(word_t a, word_t b);
		sub33 = diff_t'(a) - diff_t'(b);
	endfunction

endpackage

// ===== rtl/core/yfs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_in_if: cell request channel
// One grid cell with its E, B and J vectors.
// ----------------------------------------------------------------------------
interface yfs_in_if;
	logic  valid;
	logic  ready;
	logic  frame_start;
	logic signed [31:0] e_x;
	logic signed [31:0] e_y;
	logic signed [31:0] e_z;
	logic signed [31:0] b_x;
	logic signed [31:0] b_y;
	logic signed [31:0] b_z;
	logic signed [31:0] j_x;
	logic signed [31:0] j_y;
	logic signed [31:0] j_z;

	modport source (output valid, frame_start, e_x, e_y, e_z, b_x, b_y, b_z,
		j_x, j_y, j_z, input ready);
	modport sink (input valid, frame_start, e_x, e_y, e_z, b_x, b_y, b_z,
		j_x, j_y, j_z, output ready);
endinterface

// ===== rtl/core/yfs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_out_if: updated cell channel
// Position and new field vector of one updated cell.
// ----------------------------------------------------------------------------
interface yfs_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  out_col;
	logic [15:0] out_row;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [31:0] new_z;

	modport source (output valid, out_col, out_row, new_x, new_y, new_z, input ready);
	modport sink (input valid, out_col, out_row, new_x, new_y, new_z, output ready);
endinterface

// ===== rtl/core/yee_field_stencil_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yee_field_stencil_update_unit: streaming 2-D Yee field sub-step
// Channel  Dir  Carries
// src      in   one grid cell: frame_start, E, B, J (Q16.16)
// dst      out  updated cell: column, row, new B or E (Q16.16)
// cfg      in   register writes: mode, coef_x, coef_y, coef_t, row_width
//
// One cell is taken per cycle while src.ready is high; a result leaves after its cell has passed the
// line buffer read, job queue, multiply, and round and sum stages.
// The line buffers are registered-read memories; E is read at column and column+1, B at column.
// Reset clears counters and pipeline valids; line buffers are not cleared.
// A stalled output holds the back end; the two-entry queue absorbs the
// front end until it too fills, then src.ready drops.
// ----------------------------------------------------------------------------
module yee_field_stencil_update_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	yfs_in_if.sink                         src,
	yfs_out_if.source                      dst,
	input  logic                           cfg_we,
	input  logic [yfs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [yfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic                        mode_q;
	yfs_pkg::coef_t              coef_q;
	logic [yfs_pkg::WIDTH_W-1:0] width_q;

	yfs_pkg::job_t f_job, q_job;
	logic          f_valid, f_ready, q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= yfs_pkg::MODE_B;
			coef_q  <= '0;
			width_q <= yfs_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				yfs_pkg::REG_MODE:   mode_q    <= cfg_wdata[0];
				yfs_pkg::REG_COEF_X: coef_q.cx <= cfg_wdata;
				yfs_pkg::REG_COEF_Y: coef_q.cy <= cfg_wdata;
				yfs_pkg::REG_COEF_T: coef_q.ct <= cfg_wdata;
				yfs_pkg::REG_WIDTH:  width_q   <= cfg_wdata[yfs_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	yfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (src),
		.mode      (mode_q),
		.row_width (width_q),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	yfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (f_job),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_job    (q_job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	yfs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.job       (q_job),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.dst       (dst)
	);

endmodule

// ===== rtl/core/yfs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_front: raster tracking, line buffers and job builder
// Counts column and row, keeps the previous row of E and B, decides whether
// the cell yields a result and lays out the operands of the update.
// ----------------------------------------------------------------------------
module yfs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	yfs_in_if.sink                      src,
	input  logic                        mode,
	input  logic [yfs_pkg::WIDTH_W-1:0] row_width,
	output yfs_pkg::job_t               job,
	output logic                        job_valid,
	input  logic                        job_ready
);

	logic [yfs_pkg::COL_W-1:0]   col_q;
	logic [yfs_pkg::ROW_W-1:0]   row_q;
	logic [yfs_pkg::COL_W-1:0]   c;
	logic [yfs_pkg::ROW_W-1:0]   r;
	logic [yfs_pkg::WIDTH_W-1:0] w_eff;
	logic [yfs_pkg::WIDTH_W-1:0] c_inc;
	logic                        emit;
	logic                        accept;
	logic                        s1_free;

	logic [2:0][31:0] e_mem [yfs_pkg::MAX_ROW];
	logic [2:0][31:0] b_mem [yfs_pkg::MAX_ROW];

	logic                      s1_v_q;
	logic                      s1_emit_s1;
	logic                      s1_mode_s1;
	logic [yfs_pkg::COL_W-1:0] s1_col_s1;
	logic [yfs_pkg::ROW_W-1:0] s1_row_s1;
	yfs_pkg::word_t [2:0]      in_e_s1, in_b_s1, in_j_s1;
	yfs_pkg::word_t [2:0]      e_cur_s1, e_nxt_s1, b_cur_s1;
	yfs_pkg::word_t            lf_by_s1, lf_bz_s1;
	yfs_pkg::word_t            prev_by_q, prev_bz_q;

	assign w_eff = (row_width < yfs_pkg::WIDTH_MIN) ? yfs_pkg::WIDTH_MIN :
		(row_width > yfs_pkg::WIDTH_MAX) ? yfs_pkg::WIDTH_MAX : row_width;

	assign c     = src.frame_start ? '0 : col_q;
	assign r     = src.frame_start ? '0 : row_q;
	assign c_inc = {1'b0, c} + yfs_pkg::WIDTH_W'(1);

	always_comb begin
		if (mode == yfs_pkg::MODE_B) begin
			emit = (r != '0) && (c_inc < w_eff);
		end else begin
			emit = (r != '0) && (c != '0);
		end
	end

	assign s1_free   = !s1_v_q || !s1_emit_s1 || job_ready;
	assign src.ready = s1_free;
	assign accept    = src.valid && s1_free;
	assign job_valid = s1_v_q && s1_emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (accept) begin
				if (c_inc >= w_eff) begin
					col_q <= '0;
					row_q <= r + yfs_pkg::ROW_W'(1);
				end else begin
					col_q <= c_inc[yfs_pkg::COL_W-1:0];
					row_q <= r;
				end
				s1_v_q <= 1'b1;
			end else if (s1_free) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	// line buffers: read the previous row before this cell overwrites it
	always_ff @(posedge clk) begin
		if (accept) begin
			e_cur_s1 <= e_mem[c];
			e_nxt_s1 <= e_mem[yfs_pkg::COL_W'(c_inc)];
			b_cur_s1 <= b_mem[c];
			e_mem[c] <= {src.e_z, src.e_y, src.e_x};
			b_mem[c] <= {src.b_z, src.b_y, src.b_x};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_emit_s1 <= emit;
			s1_mode_s1 <= mode;
			s1_col_s1  <= c;
			s1_row_s1  <= (mode == yfs_pkg::MODE_B) ? r - yfs_pkg::ROW_W'(1) : r;
			in_e_s1    <= {src.e_z, src.e_y, src.e_x};
			in_b_s1    <= {src.b_z, src.b_y, src.b_x};
			in_j_s1    <= {src.j_z, src.j_y, src.j_x};
			lf_by_s1   <= prev_by_q;
			lf_bz_s1   <= prev_bz_q;
			prev_by_q  <= src.b_y;
			prev_bz_q  <= src.b_z;
		end
	end

	always_comb begin
		job       = '0;
		job.col   = s1_col_s1;
		job.row   = s1_row_s1;
		if (s1_mode_s1 == yfs_pkg::MODE_B) begin
			job.old = b_cur_s1;
			job.terms[0][0] = '{yfs_pkg::COEF_Y, 1'b1, yfs_pkg::sub33(in_e_s1[2], e_cur_s1[2])};
			job.terms[1][0] = '{yfs_pkg::COEF_X, 1'b0, yfs_pkg::sub33(e_nxt_s1[2], e_cur_s1[2])};
			job.terms[2][0] = '{yfs_pkg::COEF_X, 1'b1, yfs_pkg::sub33(e_nxt_s1[1], e_cur_s1[1])};
			job.terms[2][1] = '{yfs_pkg::COEF_Y, 1'b0, yfs_pkg::sub33(in_e_s1[0], e_cur_s1[0])};
		end else begin
			job.old = in_e_s1;
			job.terms[0][0] = '{yfs_pkg::COEF_Y, 1'b0, yfs_pkg::sub33(in_b_s1[2], b_cur_s1[2])};
			job.terms[0][1] = '{yfs_pkg::COEF_T, 1'b1, yfs_pkg::diff_t'(in_j_s1[0])};
			job.terms[1][0] = '{yfs_pkg::COEF_X, 1'b1, yfs_pkg::sub33(in_b_s1[2], lf_bz_s1)};
			job.terms[1][1] = '{yfs_pkg::COEF_T, 1'b1, yfs_pkg::diff_t'(in_j_s1[1])};
			job.terms[2][0] = '{yfs_pkg::COEF_X, 1'b0, yfs_pkg::sub33(in_b_s1[1], lf_by_s1)};
			job.terms[2][1] = '{yfs_pkg::COEF_Y, 1'b1, yfs_pkg::sub33(in_b_s1[0], b_cur_s1[0])};
			job.terms[2][2] = '{yfs_pkg::COEF_T, 1'b1, yfs_pkg::diff_t'(in_j_s1[2])};
		end
	end

endmodule

// ===== rtl/core/yfs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_queue: job queue between front and back end
// Two-entry FIFO so that either side can stall without blocking the other.
// ----------------------------------------------------------------------------
module yfs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  yfs_pkg::job_t push_job,
	input  logic          push_valid,
	output logic          push_ready,
	output yfs_pkg::job_t pop_job,
	output logic          pop_valid,
	input  logic          pop_ready
);

	yfs_pkg::job_t mem_q [yfs_pkg::QUEUE_DEPTH];
	logic          wptr_q, rptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	assign push_ready = (count_q != 2'(yfs_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_job;
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(yfs_pkg::QUEUE_DEPTH))
		else $error("queue count over depth");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wptr_q == rptr_q))
		else $error("queue empty with pointers apart");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/core/yfs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yfs_back: update arithmetic
// Multiplies each difference by its coefficient, rounds to Q16.16, sums
// with the old value and saturates into the output register.
// ----------------------------------------------------------------------------
module yfs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  yfs_pkg::coef_t coef,
	input  yfs_pkg::job_t  job,
	input  logic           job_valid,
	output logic           job_ready,
	yfs_out_if.source      dst
);

	logic                       en;
	logic                       b1_v_s1, out_v_s2;
	logic [yfs_pkg::COL_W-1:0]  col_s1, col_s2;
	logic [yfs_pkg::ROW_W-1:0]  row_s1, row_s2;
	yfs_pkg::word_t [2:0]       old_s1, res_s2;
	yfs_pkg::prod_t             prod_s1 [3][3];
	logic                       neg_s1 [3][3];
	yfs_pkg::prod_t             prod [3][3];
	yfs_pkg::word_t [2:0]       res;

	assign en        = !out_v_s2 || dst.ready;
	assign job_ready = en;

	always_comb begin
		logic [yfs_pkg::COEF_W-1:0] cv;
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				case (job.terms[i][k].sel)
					yfs_pkg::COEF_X: cv = coef.cx;
					yfs_pkg::COEF_Y: cv = coef.cy;
					yfs_pkg::COEF_T: cv = coef.ct;
					default:         cv = '0;
				endcase
				prod[i][k] = yfs_pkg::prod_t'($signed({1'b0, cv}))
					* yfs_pkg::prod_t'(job.terms[i][k].diff);
			end
		end
	end

	// round each term to Q16.16 (floor after adding half), sum, saturate
	always_comb begin
		logic signed [36:0] acc;
		logic signed [33:0] t;
		for (int i = 0; i < 3; i++) begin
			acc = 37'(old_s1[i]);
			for (int k = 0; k < 3; k++) begin
				t = 34'((prod_s1[i][k] + yfs_pkg::prod_t'(64'sd1 <<< 29)) >>> 30);
				if (neg_s1[i][k]) acc = acc - 37'(t);
				else              acc = acc + 37'(t);
			end
			if (acc > 37'sd2147483647)       res[i] = 32'sh7fffffff;
			else if (acc < -37'sd2147483648) res[i] = 32'sh80000000;
			else                             res[i] = acc[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_s1  <= 1'b0;
			out_v_s2 <= 1'b0;
		end else if (en) begin
			b1_v_s1  <= job_valid;
			out_v_s2 <= b1_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			col_s1 <= job.col;
			row_s1 <= job.row;
			old_s1 <= job.old;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[i][k] <= prod[i][k];
					neg_s1[i][k]  <= job.terms[i][k].neg;
				end
			end
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			res_s2 <= res;
		end
	end

	assign dst.valid   = out_v_s2;
	assign dst.out_col = col_s2;
	assign dst.out_row = row_s2;
	assign dst.new_x   = res_s2[0];
	assign dst.new_y   = res_s2[1];
	assign dst.new_z   = res_s2[2];

endmodule
